// ===== rtl/sct_pkg.sv =====
// sct_pkg: types and constants of the source code tokenizer.
// No dependencies.
`default_nettype none
package sct_pkg;

  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0, KIND_STRING = 4'd1, KIND_IDENT = 4'd2, KIND_KEYWORD = 4'd3,
    KIND_OPERATOR = 4'd4, KIND_NOT = 4'd5, KIND_LPAREN = 4'd6, KIND_RPAREN = 4'd7,
    KIND_COMMA = 4'd8, KIND_DOT = 4'd9, KIND_COLON = 4'd10, KIND_SEMI = 4'd11,
    KIND_QUERY = 4'd12, KIND_LBRACK = 4'd13, KIND_RBRACK = 4'd14
  } kind_e;

  typedef enum logic [4:0] {
    OP_SET = 5'd0, OP_EQ = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
    OP_DIV = 5'd5, OP_MOD = 5'd6, OP_ADD_ASSIGN = 5'd7, OP_SUB_ASSIGN = 5'd8,
    OP_MUL_ASSIGN = 5'd9, OP_DIV_ASSIGN = 5'd10, OP_MOD_ASSIGN = 5'd11,
    OP_AND_ASSIGN = 5'd12, OP_OR_ASSIGN = 5'd13, OP_AND = 5'd14, OP_OR = 5'd15,
    OP_LT = 5'd16, OP_LE = 5'd17, OP_SHL = 5'd18, OP_GT = 5'd19, OP_GE = 5'd20,
    OP_SHR = 5'd21, OP_UPLUS = 5'd22, OP_UMINUS = 5'd23, OP_PRE_INC = 5'd24,
    OP_POST_INC = 5'd25, OP_PRE_DEC = 5'd26, OP_POST_DEC = 5'd27
  } op_e;

  // Scanner modes, one-hot.
  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_IDENT   = 9'b000000010,
    M_NUMBER  = 9'b000000100,
    M_DSTR    = 9'b000001000,
    M_DESC    = 9'b000010000,
    M_SSTR    = 9'b000100000,
    M_SESC    = 9'b001000000,
    M_OP      = 9'b010000000,
    M_COMMENT = 9'b100000000
  } mode_e;

  typedef enum logic [1:0] {
    PREV_NONE = 2'd0, PREV_ID = 2'd1, PREV_NUM = 2'd2, PREV_OTHER = 2'd3
  } prev_e;

  localparam int unsigned NumKeywords = 20;
  localparam int unsigned PrefixBytes = 6;

  // Keyword texts, first byte in the low byte, with their lengths.
  localparam logic [47:0] KwText [NumKeywords] = '{
    48'h24, 48'h72616863, 48'h7261686375, 48'h65747962, 48'h6574796275,
    48'h746e69, 48'h746e6975, 48'h74616f6c66, 48'h656c62756f64, 48'h676e6f6c,
    48'h676e69727473, 48'h726f66, 48'h656c696877, 48'h6e7275746572, 48'h6669,
    48'h66696c65, 48'h65736c65, 48'h686374697773, 48'h65736163, 48'h6b61657262
  };
  localparam logic [2:0] KwLen [NumKeywords] = '{
    3'd1, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd6, 3'd4,
    3'd6, 3'd3, 3'd5, 3'd6, 3'd2, 3'd4, 3'd4, 3'd6, 3'd4, 3'd5
  };

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sct_stream_if.sv =====
// sct_stream_if: valid/ready channel carrying a generic payload.
// No dependencies.
`default_nettype none
interface sct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/source_code_tokenizer.sv =====
// source_code_tokenizer: streaming lexer, one source byte per transaction.
// Depends on sct_pkg and sct_stream_if.
`default_nettype none
// Takes one byte per cycle and emits up to two tokens per byte. Each input
// transaction is lexed in the cycle it is accepted (mode register, keyword
// compare against constants in parallel) and its tokens are written into a
// four-entry result queue, which drains one token per cycle while the receiver
// is ready. A byte that yields two tokens is absorbed at once but leaves the
// queue one token at a time; sustained rate is one byte per cycle while tokens
// average at most one per byte, and input ready falls only while the queue
// lacks room for two tokens. Tokens carry line, start offset and length, not text.
module source_code_tokenizer #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LINE_BITS     = 20,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sct_stream_if.sink   in_i,
  sct_stream_if.source out_o
);
  import sct_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdx   = $clog2(QDepth);

  localparam logic [LINE_BITS-1:0]   LineMax = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LenMax  = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic [3:0]               kind;
    logic [4:0]               op;
    logic [4:0]               kw;
    logic [LINE_BITS-1:0]     line;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   len;
  } tok_t;

  // Input payload: in_i.payload.source_byte, in_i.payload.end_of_text.
  // Output payload: token_kind, operator_code, keyword_code, line_number,
  // start_offset, text_length, last_of_run.

  // ---------------- state ----------------
  mode_e                    mode_q, mode_d;
  logic [7:0]               held_q, held_d;
  logic [47:0]              prefix_q, prefix_d;
  logic [POSITION_BITS-1:0] tstart_q, tstart_d;
  logic [LENGTH_BITS-1:0]   tlen_q, tlen_d;
  logic [POSITION_BITS-1:0] pos_q;
  logic [LINE_BITS-1:0]     line_q, line_d;
  prev_e                    prev_q, prev_d;

  // result queue
  tok_t             q_tok [QDepth];
  logic [QDepth-1:0] q_last;
  logic [QIdx-1:0]  rd_q, wr_q;
  logic [QIdx:0]    cnt_q;

  logic in_fire, out_fire;
  assign in_i.ready = (cnt_q <= (QIdx+1)'(QDepth - 2));
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // ---------------- lexing ----------------
  logic [7:0] b;
  logic       eot;
  assign b   = in_i.payload.source_byte;
  assign eot = in_i.payload.end_of_text;

  tok_t       t0, t1;
  logic [1:0] n_tok;

  // Keyword lookup on a word (prefix, length); returns match and code.
  function automatic logic [5:0] kw_find(input logic [47:0] w, input logic [LENGTH_BITS-1:0] l);
    logic [5:0] r;
    logic [47:0] m;
    r = '0;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      m = (48'h1 << (8 * KwLen[k])) - 48'h1;
      if (l == LENGTH_BITS'(KwLen[k]) && (w & m) == KwText[k]) begin
        r = {1'b1, 5'(k)};
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [LENGTH_BITS-1:0] len_inc;
    logic [LENGTH_BITS-1:0] len_cur;
    logic       used;
    logic       eq, dbl, operand;
    logic [5:0] kw;
    prev_e      pc;
    logic [LINE_BITS-1:0] ln;
    tok_t       tk;
    logic       emit_v;
    logic [3:0] pk;

    mode_d   = mode_q;
    held_d   = held_q;
    prefix_d = prefix_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    line_d   = line_q;
    pc       = prev_q;
    t0       = '0;
    t1       = '0;
    n_tok    = 2'd0;
    used     = 1'b0;
    tk       = '0;
    emit_v   = 1'b0;
    kw       = '0;
    pk       = '0;
    len_inc  = (tlen_q == LenMax) ? tlen_q : tlen_q + 1'b1;
    len_cur  = tlen_q;
    eq       = (b == 8'h3d);
    dbl      = (b == held_q);
    operand  = (prev_q == PREV_ID) || (prev_q == PREV_NUM);
    ln       = line_q;

    // continuation of the current mode (first token slot)
    unique case (mode_q)
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b)) begin
          if (tlen_q < LENGTH_BITS'(PrefixBytes))
            prefix_d = prefix_q | (48'(b) << (8 * tlen_q[2:0]));
          tlen_d = len_inc;
          used   = 1'b1;
        end else begin
          mode_d = M_IDLE;
          kw     = kw_find(prefix_q, tlen_q);
          tk     = '{kind: kw[5] ? KIND_KEYWORD : KIND_IDENT, op: '0,
                     kw: kw[5] ? kw[4:0] : 5'd0, line: ln, start: tstart_q, len: tlen_q};
          emit_v = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(b)) begin
          tlen_d = len_inc;
          used   = 1'b1;
        end else begin
          mode_d = M_IDLE;
          tk     = '{kind: KIND_NUMBER, op: '0, kw: '0, line: ln, start: tstart_q, len: tlen_q};
          emit_v = 1'b1;
        end
      end
      M_DSTR, M_SSTR: begin
        used = 1'b1;
        if (b == ((mode_q == M_DSTR) ? 8'h22 : 8'h27)) begin
          mode_d = M_IDLE;
          tk     = '{kind: KIND_STRING, op: '0, kw: '0, line: ln, start: tstart_q, len: tlen_q};
          emit_v = 1'b1;
        end else begin
          tlen_d = len_inc;
          if (b == 8'h5c) mode_d = (mode_q == M_DSTR) ? M_DESC : M_SESC;
        end
      end
      M_DESC, M_SESC: begin
        used   = 1'b1;
        tlen_d = len_inc;
        mode_d = (mode_q == M_DESC) ? M_DSTR : M_SSTR;
      end
      M_OP: begin
        mode_d = M_IDLE;
        tk     = '{kind: KIND_OPERATOR, op: '0, kw: '0, line: ln, start: tstart_q,
                   len: LENGTH_BITS'(1)};
        emit_v = 1'b1;
        priority if (eq && held_q != 8'h3d && held_q != 8'h2f) begin
          used   = 1'b1;
          tk.len = LENGTH_BITS'(2);
          unique case (held_q)
            8'h2b:   tk.op = OP_ADD_ASSIGN;
            8'h2d:   tk.op = OP_SUB_ASSIGN;
            8'h2a:   tk.op = OP_MUL_ASSIGN;
            8'h25:   tk.op = OP_MOD_ASSIGN;
            8'h26:   tk.op = OP_AND_ASSIGN;
            8'h7c:   tk.op = OP_OR_ASSIGN;
            8'h3c:   tk.op = OP_LE;
            default: tk.op = OP_GE;
          endcase
        end else if (held_q == 8'h3d) begin
          used   = eq;
          tk.op  = eq ? OP_EQ : OP_SET;
          tk.len = eq ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
        end else if (held_q == 8'h2f) begin
          if (eq) begin
            used = 1'b1; tk.op = OP_DIV_ASSIGN; tk.len = LENGTH_BITS'(2);
          end else if (dbl) begin
            used = 1'b1; emit_v = 1'b0; mode_d = M_COMMENT;
          end else begin
            tk.op = OP_DIV;
          end
        end else if (dbl && (held_q == 8'h2b || held_q == 8'h2d ||
                             held_q == 8'h3c || held_q == 8'h3e)) begin
          used   = 1'b1;
          tk.len = LENGTH_BITS'(2);
          unique case (held_q)
            8'h2b:   tk.op = (prev_q == PREV_ID) ? OP_POST_INC : OP_PRE_INC;
            8'h2d:   tk.op = (prev_q == PREV_ID) ? OP_POST_DEC : OP_PRE_DEC;
            8'h3c:   tk.op = OP_SHL;
            default: tk.op = OP_SHR;
          endcase
        end else begin
          unique case (held_q)
            8'h2b:   tk.op = operand ? OP_ADD : OP_UPLUS;
            8'h2d:   tk.op = operand ? OP_SUB : OP_UMINUS;
            8'h2a:   tk.op = OP_MUL;
            8'h25:   tk.op = OP_MOD;
            8'h26:   tk.op = OP_AND;
            8'h7c:   tk.op = OP_OR;
            8'h3c:   tk.op = OP_LT;
            default: tk.op = OP_GT;
          endcase
        end
      end
      M_COMMENT: begin
        used = 1'b1;
        if (b == 8'h0a) begin
          if (line_q != LineMax) line_d = line_q + 1'b1;
          mode_d = M_IDLE;
        end
      end
      default: mode_d = M_IDLE;
    endcase

    if (emit_v) begin
      t0    = tk;
      n_tok = 2'd1;
      pc    = (tk.kind == KIND_IDENT) ? PREV_ID :
              (tk.kind == KIND_NUMBER) ? PREV_NUM : PREV_OTHER;
    end

    // a byte not consumed by the mode above may start a new token
    tk     = '{kind: '0, op: '0, kw: '0, line: line_d, start: pos_q, len: LENGTH_BITS'(1)};
    emit_v = 1'b0;
    if (!used) begin
      priority if (is_alpha(b)) begin
        mode_d = M_IDENT; prefix_d = 48'(b); tstart_d = pos_q; tlen_d = LENGTH_BITS'(1);
      end else if (is_digit(b)) begin
        mode_d = M_NUMBER; prefix_d = '0; tstart_d = pos_q; tlen_d = LENGTH_BITS'(1);
      end else if (b == 8'h22 || b == 8'h27) begin
        mode_d   = (b == 8'h22) ? M_DSTR : M_SSTR;
        tstart_d = pos_q + 1'b1;
        tlen_d   = '0;
      end else if (b == 8'h21) begin
        tk.kind = KIND_NOT; emit_v = 1'b1;
      end else if (b == 8'h24) begin
        tk.kind = KIND_KEYWORD; emit_v = 1'b1;
      end else if (b == 8'h0a) begin
        if (line_d != LineMax) line_d = line_d + 1'b1;
      end else if (b == 8'h28 || b == 8'h29 || b == 8'h2c || b == 8'h2e || b == 8'h3a ||
                   b == 8'h3b || b == 8'h3f || b == 8'h5b || b == 8'h5d) begin
        unique case (b)
          8'h28:   pk = KIND_LPAREN;
          8'h29:   pk = KIND_RPAREN;
          8'h2c:   pk = KIND_COMMA;
          8'h2e:   pk = KIND_DOT;
          8'h3a:   pk = KIND_COLON;
          8'h3b:   pk = KIND_SEMI;
          8'h3f:   pk = KIND_QUERY;
          8'h5b:   pk = KIND_LBRACK;
          default: pk = KIND_RBRACK;
        endcase
        tk.kind = pk; emit_v = 1'b1;
      end else if (b == 8'h3d || b == 8'h2b || b == 8'h2d || b == 8'h2a || b == 8'h25 ||
                   b == 8'h26 || b == 8'h7c || b == 8'h3c || b == 8'h3e || b == 8'h2f) begin
        mode_d = M_OP; held_d = b; tstart_d = pos_q;
      end else begin
        // ignored byte
      end
    end

    // end of text: flush whatever is pending in the new mode
    if (!emit_v && eot) begin
      len_cur = tlen_d;
      tk = '{kind: '0, op: '0, kw: '0, line: line_d, start: tstart_d, len: len_cur};
      unique case (mode_d)
        M_IDENT: begin
          kw = kw_find(prefix_d, tlen_d);
          tk.kind = kw[5] ? KIND_KEYWORD : KIND_IDENT;
          tk.kw   = kw[5] ? kw[4:0] : 5'd0;
          emit_v  = 1'b1;
        end
        M_NUMBER: begin
          tk.kind = KIND_NUMBER; emit_v = 1'b1;
        end
        M_DSTR, M_SSTR, M_DESC, M_SESC: begin
          tk.kind = KIND_STRING; emit_v = 1'b1;
        end
        M_OP: begin
          tk.kind = KIND_OPERATOR;
          tk.len  = LENGTH_BITS'(1);
          emit_v  = 1'b1;
          unique case (held_d)
            8'h3d:   tk.op = OP_SET;
            8'h2b:   tk.op = (pc == PREV_ID || pc == PREV_NUM) ? OP_ADD : OP_UPLUS;
            8'h2d:   tk.op = (pc == PREV_ID || pc == PREV_NUM) ? OP_SUB : OP_UMINUS;
            8'h2a:   tk.op = OP_MUL;
            8'h25:   tk.op = OP_MOD;
            8'h26:   tk.op = OP_AND;
            8'h7c:   tk.op = OP_OR;
            8'h3c:   tk.op = OP_LT;
            8'h3e:   tk.op = OP_GT;
            default: tk.op = OP_DIV;
          endcase
        end
        default: emit_v = 1'b0;
      endcase
    end

    if (emit_v) begin
      if (n_tok == 2'd0) t0 = tk; else t1 = tk;
      n_tok = n_tok + 2'd1;
      pc    = (tk.kind == KIND_IDENT) ? PREV_ID :
              (tk.kind == KIND_NUMBER) ? PREV_NUM : PREV_OTHER;
    end
    prev_d = pc;
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      held_q   <= '0;
      prefix_q <= '0;
      tstart_q <= '0;
      tlen_q   <= '0;
      pos_q    <= '0;
      line_q   <= LINE_BITS'(1);
      prev_q   <= PREV_NONE;
    end else if (in_fire) begin
      if (eot) begin
        mode_q   <= M_IDLE;
        held_q   <= '0;
        prefix_q <= '0;
        tstart_q <= '0;
        tlen_q   <= '0;
        pos_q    <= '0;
        line_q   <= LINE_BITS'(1);
        prev_q   <= PREV_NONE;
      end else begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        prefix_q <= prefix_d;
        tstart_q <= tstart_d;
        tlen_q   <= tlen_d;
        pos_q    <= pos_q + 1'b1;
        line_q   <= line_d;
        prev_q   <= prev_d;
      end
    end
  end

  // ---------------- result queue ----------------
  logic [1:0] n_wr;
  assign n_wr = in_fire ? n_tok : 2'd0;

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      q_tok[wr_q]  <= t0;
      q_last[wr_q] <= (n_wr == 2'd1);
    end
    if (n_wr == 2'd2) begin
      q_tok[wr_q + 1'b1]  <= t1;
      q_last[wr_q + 1'b1] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QIdx'(n_wr);
      if (out_fire) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QIdx+1)'(n_wr) - (QIdx+1)'(out_fire);
    end
  end

  assign out_o.valid                 = (cnt_q != '0);
  assign out_o.payload.token_kind    = q_tok[rd_q].kind;
  assign out_o.payload.operator_code = q_tok[rd_q].op;
  assign out_o.payload.keyword_code  = q_tok[rd_q].kw;
  assign out_o.payload.line_number   = q_tok[rd_q].line;
  assign out_o.payload.start_offset  = q_tok[rd_q].start;
  assign out_o.payload.text_length   = q_tok[rd_q].len;
  assign out_o.payload.last_of_run   = q_last[rd_q];

  // ---------------- assertions ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QIdx+1)'(QDepth)) else $error("queue count overflow");
  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q)) else $error("mode not one-hot");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0) else $error("line count zero");
  a_eot_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && eot |=> mode_q == M_IDLE && pos_q == '0) else $error("end of text not reset");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking testbench of source_code_tokenizer (tokens from a byte stream).
// Depends on sct_pkg, sct_stream_if and the source_code_tokenizer RTL.
`timescale 1ns / 100ps
module tb;
  import sct_pkg::*;

  // Transaction payloads as seen at the two ports.
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } src_byte_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [4:0]  operator_code;
    logic [4:0]  keyword_code;
    logic [19:0] line_number;
    logic [31:0] start_offset;
    logic [15:0] text_length;
    logic        last_of_run;
  } token_t;

  // One queued byte; hold_first makes the driver wait for every token first.
  typedef struct {
    logic [7:0] b;
    logic       eot;
    logic       hold_first;
  } feed_t;

  localparam logic [19:0] LINE_TOP = 20'hFFFFF;
  localparam logic [15:0] LEN_TOP  = 16'hFFFF;
  localparam logic [7:0]  LF       = 8'h0a;
  localparam int          N_ITEMS  = 1200;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sct_stream_if #(.payload_t(src_byte_t)) in_if ();
  sct_stream_if #(.payload_t(token_t))    out_if ();

  source_code_tokenizer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  feed_t  feed_q[$];
  token_t token_q[$];
  int     errors = 0;
  int     tokens_waiting = 0; // registered copy of token_q.size() for the driver

  // ---------------------------------------------------------------------------
  // Lexer state mirror
  // ---------------------------------------------------------------------------
  mode_e       lx_mode;
  logic [7:0]  lx_held;
  logic [47:0] lx_prefix;
  logic [31:0] lx_start;
  logic [15:0] lx_len;
  logic [31:0] lx_pos;
  logic [19:0] lx_line;
  prev_e       lx_prev;

  string kw_names[20] = '{"$", "char", "uchar", "byte", "ubyte", "int", "uint", "float",
                          "double", "long", "string", "for", "while", "return", "if",
                          "elif", "else", "switch", "case", "break"};

  function automatic logic letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic lexer_clear();
    lx_mode = M_IDLE; lx_held = '0; lx_prefix = '0; lx_start = '0;
    lx_len = '0; lx_pos = '0; lx_line = 20'd1; lx_prev = PREV_NONE;
  endtask

  function automatic void push_token(input kind_e k, input op_e op, input int kw,
                                     input logic [31:0] st, input logic [15:0] ln);
    token_t t;
    t.token_kind = k; t.operator_code = op; t.keyword_code = kw[4:0];
    t.line_number = lx_line; t.start_offset = st; t.text_length = ln;
    t.last_of_run = 1'b0;
    token_q.push_back(t);
    lx_prev = (k == KIND_IDENT) ? PREV_ID : (k == KIND_NUMBER) ? PREV_NUM : PREV_OTHER;
  endfunction

  // Identifier or keyword; only words of up to six bytes can be keywords.
  task automatic close_word();
    int hit;
    hit = -1;
    if (lx_len <= 6)
      for (int k = 0; k < 20; k++)
        if (hit < 0 && kw_names[k].len() == lx_len) begin
          hit = k;
          for (int j = 0; j < kw_names[k].len(); j++)
            if (lx_prefix[8*j +: 8] != kw_names[k][j]) hit = -1;
        end
    if (hit >= 0) push_token(KIND_KEYWORD, OP_SET, hit, lx_start, lx_len);
    else push_token(KIND_IDENT, OP_SET, 0, lx_start, lx_len);
  endtask

  function automatic void push_op(input op_e op, input logic [15:0] ln);
    push_token(KIND_OPERATOR, op, 0, lx_start, ln);
  endfunction

  // Settle the held operator byte against the lookahead; 1 when it is consumed.
  function automatic logic settle_op(input logic have, input logic [7:0] b);
    logic eq, dbl, operand;
    eq = have && b == "=";
    dbl = have && b == lx_held;
    operand = lx_prev == PREV_ID || lx_prev == PREV_NUM;
    lx_mode = M_IDLE;
    case (lx_held)
      "=": begin if (eq) begin push_op(OP_EQ, 2); return 1; end push_op(OP_SET, 1); end
      "+": begin
        if (eq) begin push_op(OP_ADD_ASSIGN, 2); return 1; end
        if (dbl) begin
          push_op(lx_prev == PREV_ID ? OP_POST_INC : OP_PRE_INC, 2); return 1;
        end
        push_op(operand ? OP_ADD : OP_UPLUS, 1);
      end
      "-": begin
        if (eq) begin push_op(OP_SUB_ASSIGN, 2); return 1; end
        if (dbl) begin
          push_op(lx_prev == PREV_ID ? OP_POST_DEC : OP_PRE_DEC, 2); return 1;
        end
        push_op(operand ? OP_SUB : OP_UMINUS, 1);
      end
      "*": begin if (eq) begin push_op(OP_MUL_ASSIGN, 2); return 1; end push_op(OP_MUL, 1); end
      "%": begin if (eq) begin push_op(OP_MOD_ASSIGN, 2); return 1; end push_op(OP_MOD, 1); end
      "&": begin if (eq) begin push_op(OP_AND_ASSIGN, 2); return 1; end push_op(OP_AND, 1); end
      "|": begin if (eq) begin push_op(OP_OR_ASSIGN, 2); return 1; end push_op(OP_OR, 1); end
      "<": begin
        if (eq) begin push_op(OP_LE, 2); return 1; end
        if (dbl) begin push_op(OP_SHL, 2); return 1; end
        push_op(OP_LT, 1);
      end
      ">": begin
        if (eq) begin push_op(OP_GE, 2); return 1; end
        if (dbl) begin push_op(OP_SHR, 2); return 1; end
        push_op(OP_GT, 1);
      end
      "/": begin
        // '/=' takes its '='; '//' opens a comment
        if (eq) begin push_op(OP_DIV_ASSIGN, 2); return 1; end
        if (dbl) begin lx_mode = M_COMMENT; return 1; end
        push_op(OP_DIV, 1);
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic bump_line();
    if (lx_line != LINE_TOP) lx_line++;
  endtask

  task automatic bump_len();
    if (lx_len != LEN_TOP) lx_len++;
  endtask

  task automatic open_token(input logic [7:0] b, input logic [31:0] p);
    string punct;
    punct = "(),.:;?[]";
    if (letter(b)) begin
      lx_mode = M_IDENT; lx_prefix = {40'd0, b}; lx_start = p; lx_len = 1;
    end else if (numeral(b)) begin
      lx_mode = M_NUMBER; lx_prefix = '0; lx_start = p; lx_len = 1;
    end else if (b == "\"" || b == "'") begin
      lx_mode = (b == "\"") ? M_DSTR : M_SSTR; lx_start = p + 1; lx_len = 0;
    end else if (b == "!") push_token(KIND_NOT, OP_SET, 0, p, 1);
    else if (b == "$") push_token(KIND_KEYWORD, OP_SET, 0, p, 1);
    else if (b == LF) bump_line();
    else begin
      for (int k = 0; k < 9; k++)
        if (b == punct[k]) push_token(kind_e'(KIND_LPAREN + k), OP_SET, 0, p, 1);
      if (b == "=" || b == "+" || b == "-" || b == "*" || b == "%" || b == "&" ||
          b == "|" || b == "<" || b == ">" || b == "/") begin
        lx_mode = M_OP; lx_held = b; lx_start = p;
      end
    end
  endtask

  // Expected tokens of one accepted byte, appended to token_q.
  task automatic lex_byte(input logic [7:0] b, input logic eot);
    logic        used;
    int          n0;
    logic [31:0] p;
    used = 0; n0 = token_q.size(); p = lx_pos;
    case (lx_mode)
      M_IDENT:
        if (letter(b) || numeral(b)) begin
          if (lx_len < 6) lx_prefix[8*lx_len +: 8] = b;
          bump_len(); used = 1;
        end else begin lx_mode = M_IDLE; close_word(); end
      M_NUMBER:
        if (numeral(b)) begin bump_len(); used = 1; end
        else begin lx_mode = M_IDLE; push_token(KIND_NUMBER, OP_SET, 0, lx_start, lx_len); end
      M_DSTR, M_SSTR: begin
        used = 1;
        if (b == (lx_mode == M_DSTR ? 8'h22 : 8'h27)) begin
          lx_mode = M_IDLE; push_token(KIND_STRING, OP_SET, 0, lx_start, lx_len);
        end else begin
          bump_len();
          if (b == "\\") lx_mode = (lx_mode == M_DSTR) ? M_DESC : M_SESC;
        end
      end
      M_DESC, M_SESC: begin
        used = 1; bump_len();
        lx_mode = (lx_mode == M_DESC) ? M_DSTR : M_SSTR;
      end
      M_OP: used = settle_op(1'b1, b);
      M_COMMENT: begin
        used = 1;
        if (b == LF) begin bump_line(); lx_mode = M_IDLE; end
      end
      default: lx_mode = M_IDLE;
    endcase
    if (!used) open_token(b, p);
    lx_pos = p + 1;
    if (eot) begin
      case (lx_mode)
        M_IDENT: close_word();
        M_NUMBER: push_token(KIND_NUMBER, OP_SET, 0, lx_start, lx_len);
        M_DSTR, M_SSTR, M_DESC, M_SESC:
          push_token(KIND_STRING, OP_SET, 0, lx_start, lx_len);
        M_OP: void'(settle_op(1'b0, 8'h00));
        default: ;
      endcase
      lexer_clear();
    end
    if (token_q.size() > n0) token_q[token_q.size() - 1].last_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Source text generation
  // ---------------------------------------------------------------------------
  task automatic put(input logic [7:0] b);
    feed_t f;
    f.b = b; f.eot = 1'b0; f.hold_first = 1'b0;
    feed_q.push_back(f);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic end_text();
    feed_q[feed_q.size() - 1].eot = 1'b1;
  endtask

  function automatic logic [7:0] word_char(input logic first);
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    return pool[$urandom_range(0, first ? 52 : 62)];
  endfunction

  // One lexical fragment with random content, mostly well formed.
  task automatic put_fragment();
    string ops, seconds, punct;
    int    n;
    logic [7:0] q;
    ops = "=+-*%&|<>/"; seconds = "=+-<>/x1 "; punct = "(),.:;?[]";
    case ($urandom_range(0, 13))
      0, 1: begin
        put_text(kw_names[$urandom_range(0, 19)]);
        if ($urandom_range(0, 3) == 0) put(word_char(1'b0));
      end
      2, 3: begin
        n = $urandom_range(1, 9);
        put(word_char(1'b1));
        repeat (n - 1) put(word_char(1'b0));
      end
      4: repeat ($urandom_range(1, 6)) put(8'($urandom_range("0", "9")));
      5: begin
        q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
        put(q);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0: begin put("\\"); put($urandom_range(0, 1) ? q : 8'($urandom_range(32, 126))); end
            1: put(LF);
            default: put(8'($urandom_range(32, 126)) == q ? "a" : 8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) put(q);
      end
      6, 7: begin
        put(ops[$urandom_range(0, 9)]);
        if ($urandom_range(0, 2) != 0) put(seconds[$urandom_range(0, 8)]);
      end
      8: put(punct[$urandom_range(0, 8)]);
      9: begin
        put_text("//");
        repeat ($urandom_range(0, 6)) put(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) != 0) put(LF);
      end
      10: put(LF);
      11: put(" ");
      12: put($urandom_range(0, 1) ? "!" : "$");
      default: put(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic put_chunk();
    repeat ($urandom_range(3, 30)) put_fragment();
    end_text();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, fed from feed_q
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (feed_q.size() == 0 ||
                   (feed_q[0].hold_first && (in_if.valid || tokens_waiting != 0))) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.payload.source_byte <= feed_q[0].b;
        in_if.payload.end_of_text <= feed_q[0].eot;
        void'(feed_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changing stall density, plus one long hold-off
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_hold  = 0;
  int rx_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 400 == 0) rx_stall <= $urandom_range(0, 3) * 25;
      if (rx_cycle == 400) rx_hold <= 300;
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_stall);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each token transaction, predicts from each byte transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    token_t want, got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token %p", $time, got);
          errors++;
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            $display("%0t: token mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        lex_byte(in_if.payload.source_byte, in_if.payload.end_of_text);
      tokens_waiting <= token_q.size();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic held_once;
    held_once = 1'b0;
    lexer_clear();
    // Directed: auto sign, post/pre increments, binary minus, '/=', comment
    // newline, escaped quote, then text ending on a held operator.
    put_text("$ a++ ++b-1/=x//c"); put(LF);
    put_text("\"q\\\"\n\" x"); put(8'hff); put(8'h00); put_text("+");
    end_text();
    put_text("word"); end_text();
    while (feed_q.size() < N_ITEMS) begin
      put_chunk();
      // sender waits for the output to drain once
      if (!held_once && feed_q.size() > N_ITEMS / 2) begin
        put_chunk();
        feed_q[feed_q.size() - 1].hold_first = 1'b1;
        held_once = 1'b1;
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (feed_q.size() != 0 || in_if.valid || token_q.size() != 0);
    repeat (20) @(posedge clk_i);
    if (token_q.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived", $time, token_q.size());
      errors++;
    end
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #8ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sct_pkg.sv
rtl/sct_stream_if.sv
rtl/source_code_tokenizer.sv
sim/tb.sv
